// ----- hw/rtl/flru_pkg.sv -----
// Shared types and constants for the FIFO/LRU page replacement block.
package flru_pkg;

    // Configuration register indexes
    localparam logic CFG_POLICY_MODE   = 1'b0;
    localparam logic CFG_FRAMES_IN_USE = 1'b1;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;

    // Replacement policy codes
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    localparam logic [3:0] FRAMES_IN_USE_RESET = 4'd8;

    // One page reference
    typedef struct packed {
        logic [15:0] page;
        logic        last_reference;
    } ref_beat_t;

    // One lookup result
    typedef struct packed {
        logic        hit;
        logic [2:0]  frame_slot;
        logic        evicted_valid;
        logic [15:0] evicted_page;
        logic [31:0] fault_count;
        logic        final_total;
    } res_beat_t;

endpackage

// ----- hw/rtl/flru_frame_store.sv -----
// Frame table memory: page number and age per frame, registered read.
module flru_frame_store #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16,
    parameter int AGE_BITS  = 16
) (
    input  logic                                   clk,
    input  logic                                   rd_en,
    input  logic [(FRAMES > 1 ? $clog2(FRAMES) : 1)-1:0] rd_addr,
    output logic [PAGE_BITS-1:0]                   rd_page,
    output logic [AGE_BITS-1:0]                    rd_age,
    input  logic                                   wr_en,
    input  logic [(FRAMES > 1 ? $clog2(FRAMES) : 1)-1:0] wr_addr,
    input  logic [PAGE_BITS-1:0]                   wr_page,
    input  logic [AGE_BITS-1:0]                    wr_age
);

    logic [PAGE_BITS-1:0] page_mem [FRAMES];
    logic [AGE_BITS-1:0]  age_mem  [FRAMES];
    logic [PAGE_BITS-1:0] rd_page_reg;
    logic [AGE_BITS-1:0]  rd_age_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            page_mem[wr_addr] <= wr_page;
            age_mem[wr_addr]  <= wr_age;
        end
    end

    // Read port, registered output
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_page_reg <= page_mem[rd_addr];
            rd_age_reg  <= age_mem[rd_addr];
        end
    end

    assign rd_page = rd_page_reg;
    assign rd_age  = rd_age_reg;

endmodule

// ----- hw/rtl/fifo_lru_page_replacement.sv -----
// Page replacement unit (FIFO or LRU) over a small bank of frames.
//
// Each reference beat is looked up against the active frames, read one entry
// per cycle from the frame memory. A single pass finds the first hit, the first
// empty frame and the oldest frame, and writes every occupied entry back with
// its age advanced. A final fix-up state then loads the page into the chosen
// frame on a miss, or resets its age on an LRU hit, and updates the fault count.
// An item passes through the accept step, a scan over the active frames
// (frames_in_use clamped to 1..FRAMES), paced by the single read port of the
// frame memory, and the fix-up; the result is valid in the cycle after the
// fix-up, the next reference is taken once the result is registered, and
// a result that is held by res_stall delays only the fix-up. The frame
// memory needs no clearing after reset: occupancy is kept in flip-flops and an
// entry's contents are used only once it has been written.
module fifo_lru_page_replacement #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16,
    parameter int AGE_BITS  = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 ref_valid,
    output logic                                 ref_stall,
    input  flru_pkg::ref_beat_t                  ref_data,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output flru_pkg::res_beat_t                  res_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [flru_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [flru_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import flru_pkg::*;

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam int CMP_W = 8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIX
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic       policy_reg;
    logic [3:0] frames_reg;

    // Control
    logic [CNT_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic              dval_reg, dval_next;
    logic [IDX_W-1:0]  didx_reg, didx_next;
    logic [FRAMES-1:0] frame_valid_reg, frame_valid_next;
    logic [31:0]       faults_reg, faults_next;
    logic              res_valid_reg, res_valid_next;

    // Scan trackers
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic              empty_found_reg, empty_found_next;
    logic [IDX_W-1:0]  empty_idx_reg, empty_idx_next;
    logic              best_valid_reg, best_valid_next;
    logic [AGE_BITS-1:0]  best_age_reg, best_age_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [PAGE_BITS-1:0] best_page_reg, best_page_next;

    // Item payload
    logic [PAGE_BITS-1:0] pg_reg, pg_next;
    logic                 last_reg, last_next;
    res_beat_t            res_data_reg, res_data_next;

    // Memory port signals
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [PAGE_BITS-1:0] rd_page;
    logic [AGE_BITS-1:0]  rd_age;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [PAGE_BITS-1:0] wr_page;
    logic [AGE_BITS-1:0]  wr_age;

    // Helpers
    logic [CMP_W-1:0]     act_n;
    logic [CMP_W-1:0]     frames_ext;
    logic [AGE_BITS-1:0]  age_inc;
    logic [31:0]          ref_page_ext;
    logic [31:0]          best_page_ext;
    logic [IDX_W-1:0]     slot;
    logic [CMP_W-1:0]     slot_ext;
    logic                 evict;
    logic                 out_free;

    flru_frame_store #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .AGE_BITS  (AGE_BITS)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_page (rd_page),
        .rd_age  (rd_age),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_page (wr_page),
        .wr_age  (wr_age)
    );

    // Clamp the active frame count to 1..FRAMES
    always_comb
    begin
        frames_ext = CMP_W'(frames_reg);
        if (frames_ext == '0)
            act_n = CMP_W'(1);
        else if (frames_ext > CMP_W'(FRAMES))
            act_n = CMP_W'(FRAMES);
        else
            act_n = frames_ext;
    end

    assign age_inc       = (rd_age == '1) ? rd_age : AGE_BITS'(rd_age + 1'b1);
    assign ref_page_ext  = 32'(ref_data.page);
    assign best_page_ext = 32'(best_page_reg);
    assign evict         = !found_reg && !empty_found_reg;
    assign slot          = found_reg ? hit_idx_reg :
                           (empty_found_reg ? empty_idx_reg : best_idx_reg);
    assign slot_ext      = CMP_W'(slot);
    assign out_free      = !res_valid_reg || !res_stall;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_LRU;
            frames_reg <= FRAMES_IN_USE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_POLICY_MODE)
                policy_reg <= cfg_data[0];
            else
                frames_reg <= cfg_data[3:0];
        end
    end

    // Sequencer: accept, scan with write-back, fix up chosen frame
    always_comb
    begin
        state_next       = state_reg;
        rd_cnt_next      = rd_cnt_reg;
        dval_next        = dval_reg;
        didx_next        = didx_reg;
        frame_valid_next = frame_valid_reg;
        faults_next      = faults_reg;
        res_valid_next   = res_valid_reg;
        found_next       = found_reg;
        hit_idx_next     = hit_idx_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        best_valid_next  = best_valid_reg;
        best_age_next    = best_age_reg;
        best_idx_next    = best_idx_reg;
        best_page_next   = best_page_reg;
        pg_next          = pg_reg;
        last_next        = last_reg;
        res_data_next    = res_data_reg;
        rd_en            = 1'b0;
        rd_addr          = rd_cnt_reg[IDX_W-1:0];
        wr_en            = 1'b0;
        wr_addr          = didx_reg;
        wr_page          = rd_page;
        wr_age           = age_inc;

        // Drop the result once taken
        if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (ref_valid)
                begin
                    rd_en            = 1'b1;
                    rd_addr          = '0;
                    rd_cnt_next      = CNT_W'(1);
                    dval_next        = 1'b1;
                    didx_next        = '0;
                    found_next       = 1'b0;
                    empty_found_next = 1'b0;
                    best_valid_next  = 1'b0;
                    pg_next          = ref_page_ext[PAGE_BITS-1:0];
                    last_next        = ref_data.last_reference;
                    state_next       = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Issue the next read
                if (CMP_W'(rd_cnt_reg) < act_n)
                begin
                    rd_en       = 1'b1;
                    rd_cnt_next = CNT_W'(rd_cnt_reg + 1'b1);
                    dval_next   = 1'b1;
                    didx_next   = rd_cnt_reg[IDX_W-1:0];
                end
                else
                begin
                    dval_next = 1'b0;
                end

                // Examine returned entry, age it in place
                if (dval_reg)
                begin
                    if (frame_valid_reg[didx_reg])
                    begin
                        wr_en = 1'b1;
                        if (!found_reg && rd_page == pg_reg)
                        begin
                            found_next   = 1'b1;
                            hit_idx_next = didx_reg;
                        end
                        if (!best_valid_reg || rd_age > best_age_reg)
                        begin
                            best_valid_next = 1'b1;
                            best_age_next   = rd_age;
                            best_idx_next   = didx_reg;
                            best_page_next  = rd_page;
                        end
                    end
                    else if (!empty_found_reg)
                    begin
                        empty_found_next = 1'b1;
                        empty_idx_next   = didx_reg;
                    end

                    if (CMP_W'(didx_reg) == CMP_W'(act_n - 1'b1))
                        state_next = S_FIX;
                end
            end

            S_FIX:
            begin
                if (out_free)
                begin
                    // Load page into chosen frame, or reset the age on an LRU hit
                    if (!found_reg || policy_reg == POLICY_LRU)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = slot;
                        wr_page = pg_reg;
                        wr_age  = AGE_BITS'(1);
                    end
                    if (!found_reg)
                    begin
                        frame_valid_next[slot] = 1'b1;
                        if (faults_reg != '1)
                            faults_next = faults_reg + 32'd1;
                    end

                    res_data_next.hit           = found_reg;
                    res_data_next.frame_slot    = slot_ext[2:0];
                    res_data_next.evicted_valid = evict;
                    res_data_next.evicted_page  = evict ? best_page_ext[15:0] : 16'd0;
                    res_data_next.fault_count   = faults_next;
                    res_data_next.final_total   = last_reg;
                    res_valid_next              = 1'b1;
                    state_next                  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            rd_cnt_reg      <= '0;
            dval_reg        <= 1'b0;
            frame_valid_reg <= '0;
            faults_reg      <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            rd_cnt_reg      <= rd_cnt_next;
            dval_reg        <= dval_next;
            frame_valid_reg <= frame_valid_next;
            faults_reg      <= faults_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    // Hold payload and scan trackers
    always_ff @(posedge clk)
    begin
        didx_reg        <= didx_next;
        found_reg       <= found_next;
        hit_idx_reg     <= hit_idx_next;
        empty_found_reg <= empty_found_next;
        empty_idx_reg   <= empty_idx_next;
        best_valid_reg  <= best_valid_next;
        best_age_reg    <= best_age_next;
        best_idx_reg    <= best_idx_next;
        best_page_reg   <= best_page_next;
        pg_reg          <= pg_next;
        last_reg        <= last_next;
        res_data_reg    <= res_data_next;
    end

    assign ref_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the FIFO/LRU page replacement unit.
`timescale 1ns / 100ps

module testbench;

    import flru_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_TAIL     = 20;
    localparam int SOAK_HITS      = 40;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_REFS     = 130;
    localparam int POOL_SIZE      = 12;
    localparam int BUILT_FRAMES   = 8;

    typedef enum logic {
        ROW_REF,
        ROW_CFG
    } row_kind_t;

    // One line of the directed script: a reference beat or a register write
    typedef struct packed {
        row_kind_t                kind;
        ref_beat_t                beat;
        logic                     pinned;
        res_beat_t                want;
        logic [CFG_INDEX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]    reg_val;
    } script_row_t;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     ref_valid = 1'b0;
    logic                     ref_stall;
    ref_beat_t                ref_data = '0;
    logic                     res_valid;
    logic                     res_stall = 1'b0;
    res_beat_t                res_data;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    // Typed-in expectation that travels with the current reference beat
    logic                     pin_on = 1'b0;
    res_beat_t                pin_res = '0;

    // Shadow copy of the frame bank and registers
    logic [15:0]              fr_page [BUILT_FRAMES];
    logic                     fr_used [BUILT_FRAMES];
    logic [15:0]              fr_age [BUILT_FRAMES];
    logic [31:0]              fault_tally = '0;
    logic                     cur_policy = POLICY_LRU;
    logic [3:0]               cur_frames = FRAMES_IN_USE_RESET;

    res_beat_t                pending_results [$];
    script_row_t              script_rows [$];
    logic [15:0]              hot_pages [POOL_SIZE];

    int                       refs_sent = 0;
    int                       results_seen = 0;
    int                       fail_count = 0;
    int                       stall_left = 0;
    bit                       quiet = 1'b0;
    bit                       calm_tx = 1'b0;
    bit                       calm_rx = 1'b0;

    fifo_lru_page_replacement dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .ref_valid (ref_valid),
        .ref_stall (ref_stall),
        .ref_data  (ref_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < BUILT_FRAMES; i++)
        begin
            fr_page[i] = '0;
            fr_used[i] = 1'b0;
            fr_age[i]  = '0;
        end
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pause_len(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || calm)
            return 0;
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Look one page up in the shadow frame bank and advance its state
    function automatic res_beat_t lookup_page(ref_beat_t b);
        res_beat_t   o;
        int          n;
        int          slot;
        bit          found;
        bit          empty;
        logic [15:0] oldest;
        o     = '0;
        slot  = 0;
        found = 1'b0;
        empty = 1'b0;
        n = (cur_frames == 0) ? 1 : (cur_frames > BUILT_FRAMES) ? BUILT_FRAMES : cur_frames;

        for (int i = 0; i < n; i++)
        begin
            if (!found && fr_used[i] && fr_page[i] == b.page)
            begin
                slot  = i;
                found = 1'b1;
            end
        end

        if (found)
        begin
            if (cur_policy == POLICY_LRU)
                fr_age[slot] = '0;
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                if (!empty && !fr_used[i])
                begin
                    slot  = i;
                    empty = 1'b1;
                end
            end
            // No free frame: replace the oldest, lowest index on ties
            if (!empty)
            begin
                slot   = 0;
                oldest = fr_age[0];
                for (int i = 1; i < n; i++)
                begin
                    if (fr_age[i] > oldest)
                    begin
                        oldest = fr_age[i];
                        slot   = i;
                    end
                end
                o.evicted_valid = 1'b1;
                o.evicted_page  = fr_page[slot];
                fr_age[slot]    = '0;
            end
            fr_page[slot] = b.page;
            fr_used[slot] = 1'b1;
            if (fault_tally != '1)
                fault_tally++;
        end

        // Age every occupied active frame, saturating
        for (int i = 0; i < n; i++)
        begin
            if (fr_used[i] && fr_age[i] != '1)
                fr_age[i]++;
        end

        o.hit         = found;
        o.frame_slot  = 3'(slot);
        o.fault_count = fault_tally;
        o.final_total = b.last_reference;
        return o;
    endfunction

    function automatic res_beat_t outcome(logic hit, logic [2:0] frame, logic ev_valid,
                                          logic [15:0] ev_page, logic [31:0] faults,
                                          logic last);
        res_beat_t o;
        o.hit           = hit;
        o.frame_slot    = frame;
        o.evicted_valid = ev_valid;
        o.evicted_page  = ev_page;
        o.fault_count   = faults;
        o.final_total   = last;
        return o;
    endfunction

    function automatic void add_ref(logic [15:0] page, logic last, logic pinned,
                                    res_beat_t want);
        script_row_t row;
        row                     = '0;
        row.kind                = ROW_REF;
        row.beat.page           = page;
        row.beat.last_reference = last;
        row.pinned              = pinned;
        row.want                = want;
        script_rows.insert(script_rows.size(), row);
    endfunction

    function automatic void add_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        script_row_t row;
        row         = '0;
        row.kind    = ROW_CFG;
        row.reg_idx = idx;
        row.reg_val = val;
        script_rows.insert(script_rows.size(), row);
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Track register writes, predict accepted beats, check result beats
    always @(posedge clk)
    begin : monitor
        res_beat_t guess;
        res_beat_t want;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_POLICY_MODE)
                cur_policy = cfg_data[0];
            else
                cur_frames = cfg_data;
        end
        if (ref_valid && !ref_stall)
        begin
            guess = lookup_page(ref_data);
            pending_results.insert(pending_results.size(), pin_on ? pin_res : guess);
        end
        if (res_valid && !res_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("hit", want.hit, res_data.hit);
                compare_field("frame_slot", want.frame_slot, res_data.frame_slot);
                compare_field("evicted_valid", want.evicted_valid, res_data.evicted_valid);
                compare_field("evicted_page", want.evicted_page, res_data.evicted_page);
                compare_field("fault_count", want.fault_count, res_data.fault_count);
                compare_field("final_total", want.final_total, res_data.final_total);
            end
        end
    end

    // Stall the result side at random, with calm stretches
    always @(posedge clk)
    begin
        if (!quiet && $urandom_range(0, 199) == 0)
            calm_rx = !calm_rx;
        if (stall_left != 0)
        begin
            stall_left--;
            res_stall <= 1'b1;
        end
        else if (!quiet && !calm_rx && $urandom_range(0, 3) == 0)
        begin
            stall_left = pause_len(1'b0);
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= 1'b0;
        end
    end

    // End the run when no beat moves on any channel for too long
    initial
    begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((ref_valid && !ref_stall) || (res_valid && !res_stall) ||
                (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Present one reference beat after a random gap; return at its accept edge
    task automatic send_ref(ref_beat_t beat, logic pinned, res_beat_t want);
        int gap;
        if ($urandom_range(0, 49) == 0)
            calm_tx = !calm_tx;
        gap = pause_len(calm_tx);
        if (gap > 0)
        begin
            ref_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ref_valid <= 1'b1;
        ref_data  <= beat;
        pin_on    <= pinned;
        pin_res   <= want;
        @(posedge clk);
        while (ref_stall)
            @(posedge clk);
        refs_sent++;
    endtask

    // Hold off new beats until every result is back
    task automatic settle();
        ref_valid <= 1'b0;
        while (results_seen != refs_sent)
            @(posedge clk);
    endtask

    // Write one register; keep valid up when another write follows
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val, bit more);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (!more)
            cfg_valid <= 1'b0;
    endtask

    task automatic send_page(logic [15:0] page, logic last);
        ref_beat_t beat;
        beat.page           = page;
        beat.last_reference = last;
        send_ref(beat, 1'b0, '0);
    endtask

    initial
    begin
        ref_beat_t   beat;
        logic [3:0]  frames;
        logic        policy;
        int          span;
        bit          more;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed script: fill from reset, evict, then walk the registers
        add_ref(16'h0000, 1'b0, 1'b1, outcome(1'b0, 3'd0, 1'b0, 16'h0, 32'd1, 1'b0));
        add_ref(16'hFFFF, 1'b0, 1'b1, outcome(1'b0, 3'd1, 1'b0, 16'h0, 32'd2, 1'b0));
        add_ref(16'h0000, 1'b0, 1'b1, outcome(1'b1, 3'd0, 1'b0, 16'h0, 32'd2, 1'b0));
        add_ref(16'h1111, 1'b0, 1'b1, outcome(1'b0, 3'd2, 1'b0, 16'h0, 32'd3, 1'b0));
        add_ref(16'h2222, 1'b0, 1'b1, outcome(1'b0, 3'd3, 1'b0, 16'h0, 32'd4, 1'b0));
        add_ref(16'h4444, 1'b0, 1'b1, outcome(1'b0, 3'd4, 1'b0, 16'h0, 32'd5, 1'b0));
        add_ref(16'h8888, 1'b0, 1'b1, outcome(1'b0, 3'd5, 1'b0, 16'h0, 32'd6, 1'b0));
        add_ref(16'hAAAA, 1'b1, 1'b1, outcome(1'b0, 3'd6, 1'b0, 16'h0, 32'd7, 1'b1));
        add_ref(16'h5555, 1'b0, 1'b1, outcome(1'b0, 3'd7, 1'b0, 16'h0, 32'd8, 1'b0));
        add_ref(16'h1234, 1'b0, 1'b0, '0);
        add_ref(16'h5555, 1'b0, 1'b0, '0);
        add_cfg(CFG_POLICY_MODE, POLICY_FIFO);
        add_ref(16'h0000, 1'b0, 1'b0, '0);
        add_ref(16'h7777, 1'b0, 1'b0, '0);
        add_ref(16'h7777, 1'b0, 1'b0, '0);
        // Zero frames behaves as one
        add_cfg(CFG_FRAMES_IN_USE, 4'd0);
        add_ref(16'h1111, 1'b0, 1'b0, '0);
        add_ref(16'h0000, 1'b1, 1'b0, '0);
        // Above the built count behaves as all frames
        add_cfg(CFG_FRAMES_IN_USE, 4'd15);
        add_ref(16'h5555, 1'b0, 1'b0, '0);
        add_ref(16'h9999, 1'b0, 1'b0, '0);
        add_cfg(CFG_FRAMES_IN_USE, 4'd3);
        add_cfg(CFG_POLICY_MODE, POLICY_LRU);
        add_ref(16'hABCD, 1'b0, 1'b0, '0);
        add_ref(16'hABCD, 1'b1, 1'b0, '0);
        add_ref(16'h2468, 1'b0, 1'b0, '0);
        add_cfg(CFG_FRAMES_IN_USE, 4'd8);
        add_ref(16'hFFFF, 1'b0, 1'b0, '0);

        for (int k = 0; k < script_rows.size(); k++)
        begin
            if (script_rows[k].kind == ROW_CFG)
            begin
                more = (k + 1 < script_rows.size()) && (script_rows[k + 1].kind == ROW_CFG);
                settle();
                write_reg(script_rows[k].reg_idx, script_rows[k].reg_val, more);
            end
            else
            begin
                send_ref(script_rows[k].beat, script_rows[k].pinned, script_rows[k].want);
            end
        end

        // Soak two frames in FIFO mode with repeated hits, then force a replacement
        settle();
        quiet = 1'b1;
        write_reg(CFG_POLICY_MODE, POLICY_FIFO, 1'b1);
        write_reg(CFG_FRAMES_IN_USE, 4'd2, 1'b0);
        send_page(16'hC3A5, 1'b0);
        send_page(16'h3C5A, 1'b0);
        for (int k = 0; k < SOAK_HITS; k++)
            send_page(16'hC3A5, 1'b0);
        send_page(16'h0001, 1'b1);
        settle();
        quiet = 1'b0;

        for (int i = 0; i < POOL_SIZE; i++)
            hot_pages[i] = 16'($urandom_range(0, 65535));

        // Random phases: skewed reference strings over a shifting hot set
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: frames = 4'd8;
                1: frames = 4'd1;
                2: frames = 4'd15;
                3: frames = 4'd0;
                4: frames = 4'($urandom_range(2, 7));
                default: frames = 4'($urandom_range(9, 14));
            endcase
            policy = (ph % 2 == 0) ? POLICY_LRU : POLICY_FIFO;
            span = $urandom_range(3, POOL_SIZE - 1);
            repeat (3) hot_pages[$urandom_range(0, POOL_SIZE - 1)] = 16'($urandom_range(0, 65535));

            settle();
            write_reg(CFG_POLICY_MODE, policy, 1'b1);
            write_reg(CFG_FRAMES_IN_USE, frames, 1'b0);

            for (int k = 0; k < PHASE_REFS; k++)
            begin
                if (ph == 2 && k == PHASE_REFS / 2)
                    settle();
                if ($urandom_range(0, 99) < 85)
                    beat.page = hot_pages[$urandom_range(0, span)];
                else
                    beat.page = 16'($urandom_range(0, 65535));
                beat.last_reference = ($urandom_range(0, 15) == 0);
                send_ref(beat, 1'b0, '0);
            end
        end

        // Drain, watch for stray results, then check that none are missing
        settle();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/flru_pkg.sv
hw/rtl/flru_frame_store.sv
hw/rtl/fifo_lru_page_replacement.sv
test/testbench.sv
